// ===== src/clni_pkg.sv =====
`timescale 1ns / 1ps

package clni_pkg;

    // width of the phase tick counter
    localparam int TIMER_BITS = 8;

    // largest count the tick counter holds, kept wide enough for TIMER_BITS up to 17
    localparam logic [16:0] TMAX_W = 17'((1 << TIMER_BITS) - 1);

    // request codes
    localparam logic [2:0] CMD_IDLE   = 3'd0;
    localparam logic [2:0] CMD_INSTR  = 3'd1;
    localparam logic [2:0] CMD_DATA   = 3'd2;
    localparam logic [2:0] CMD_CURSOR = 3'd3;
    localparam logic [2:0] CMD_INIT   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_POWERUP_WAIT    = 3'd0;
    localparam logic [2:0] CFG_FIRST_INIT_WAIT = 3'd1;
    localparam logic [2:0] CFG_PULSE_TICKS     = 3'd2;
    localparam logic [2:0] CFG_SHORT_WAIT      = 3'd3;
    localparam logic [2:0] CFG_LONG_WAIT       = 3'd4;

    // power-up sequence
    localparam logic [3:0] INIT_LEN   = 4'd9;
    localparam logic [3:0] INIT_NIBS  = 4'd4;

    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_HOME  = 8'h02;
    localparam logic [7:0] DDRAM_SET   = 8'h80;
    localparam logic [7:0] LINE2_BASE  = 8'h40;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic       line_two;
    } item_t;

    typedef struct packed {
        logic       rejected;
        logic       busy_res;
        logic [3:0] data_nibble;
        logic       enable_pin;
        logic       reg_select;
    } res_t;

    typedef struct packed {
        logic       we;
        logic [2:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    // register value to tick count: zero counts as one, saturate to the counter
    function automatic logic [TIMER_BITS-1:0] ticks_of(input logic [7:0] v);
        logic [16:0] t;
        t = {9'd0, v};
        if (t == 17'd0) t = 17'd1;
        if (t > TMAX_W) t = TMAX_W;
        return t[TIMER_BITS-1:0];
    endfunction

    // bytes of the power-up sequence
    function automatic logic [7:0] init_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h30;
            4'd1:    b = 8'h30;
            4'd2:    b = 8'h30;
            4'd3:    b = 8'h20;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h06;
            4'd8:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/clni_in_stage.sv =====
`timescale 1ns / 1ps

module clni_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic [2:0]    s_tuser,
    input  logic          take,
    output logic          item_valid,
    output clni_pkg::item_t item
);

    logic            valid_reg;
    clni_pkg::item_t item_reg;

    // free slot, or the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.command    <= s_tuser;
            item_reg.byte_value <= s_tdata[7:0];
            item_reg.column     <= s_tdata[13:8];
            item_reg.line_two   <= s_tdata[14];
        end
    end

endmodule

// ===== src/clni_seq.sv =====
`timescale 1ns / 1ps

module clni_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  clni_pkg::cfg_wr_t cfg,
    input  logic              step,
    input  clni_pkg::item_t   item,
    output clni_pkg::res_t    res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PWAIT = 3'd1;
    localparam logic [2:0] PH_HI_E  = 3'd2;
    localparam logic [2:0] PH_HI_L  = 3'd3;
    localparam logic [2:0] PH_LO_E  = 3'd4;
    localparam logic [2:0] PH_LO_L  = 3'd5;
    localparam logic [2:0] PH_WAIT  = 3'd6;

    logic [7:0] powerup_wait_reg, first_init_wait_reg, pulse_ticks_reg;
    logic [7:0] short_wait_reg, long_wait_reg;

    logic [2:0]                     phase_reg, phase_next;
    logic [clni_pkg::TIMER_BITS-1:0] timer_reg, timer_next;
    logic [7:0]                     held_byte_reg, held_byte_next;
    logic                           held_rs_reg, held_rs_next;
    logic [3:0]                     init_step_reg, init_step_next;
    logic                           init_active_reg, init_active_next;
    logic [5:0]                     pins_reg, pins_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powerup_wait_reg    <= 8'd40;
            first_init_wait_reg <= 8'd5;
            pulse_ticks_reg     <= 8'd1;
            short_wait_reg      <= 8'd1;
            long_wait_reg       <= 8'd2;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                clni_pkg::CFG_POWERUP_WAIT:    powerup_wait_reg    <= cfg.data;
                clni_pkg::CFG_FIRST_INIT_WAIT: first_init_wait_reg <= cfg.data;
                clni_pkg::CFG_PULSE_TICKS:     pulse_ticks_reg     <= cfg.data;
                clni_pkg::CFG_SHORT_WAIT:      short_wait_reg      <= cfg.data;
                clni_pkg::CFG_LONG_WAIT:       long_wait_reg       <= cfg.data;
                default:                       ;
            endcase
        end
    end

    // one tick: request, pin output, then timer advance
    always_comb
    begin
        logic [7:0] sb;
        logic       rej;
        logic       busy;
        logic [3:0] nstep;

        phase_next       = phase_reg;
        timer_next       = timer_reg;
        held_byte_next   = held_byte_reg;
        held_rs_next     = held_rs_reg;
        init_step_next   = init_step_reg;
        init_active_next = init_active_reg;
        pins_next        = pins_reg;
        rej              = 1'b0;
        sb               = item.byte_value;
        nstep            = init_step_reg + 4'd1;

        if (item.command == clni_pkg::CMD_INSTR || item.command == clni_pkg::CMD_DATA ||
            item.command == clni_pkg::CMD_CURSOR || item.command == clni_pkg::CMD_INIT)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else if (item.command == clni_pkg::CMD_INIT)
            begin
                init_active_next = 1'b1;
                init_step_next   = 4'd0;
                held_rs_next     = 1'b0;
                phase_next       = PH_PWAIT;
                timer_next       = clni_pkg::ticks_of(powerup_wait_reg);
            end
            else
            begin
                init_active_next = 1'b0;
                if (item.command == clni_pkg::CMD_CURSOR)
                begin
                    sb = clni_pkg::DDRAM_SET | (item.line_two ?
                         (clni_pkg::LINE2_BASE + {2'b00, item.column}) : {2'b00, item.column});
                end
                held_byte_next = sb;
                held_rs_next   = (item.command == clni_pkg::CMD_DATA);
                phase_next     = PH_HI_E;
                timer_next     = clni_pkg::ticks_of(pulse_ticks_reg);
                pins_next      = {sb[7:4], 1'b1, held_rs_next};
            end
        end

        busy = (phase_next != PH_IDLE);
        res.reg_select  = pins_next[0];
        res.enable_pin  = pins_next[1];
        res.data_nibble = pins_next[5:2];
        res.busy_res    = busy;
        res.rejected    = rej;

        if (busy)
        begin
            if (timer_next > clni_pkg::TIMER_BITS'(1))
            begin
                timer_next = timer_next - clni_pkg::TIMER_BITS'(1);
            end
            else
            begin
                timer_next = '0;
                unique case (phase_next)
                    PH_PWAIT:
                    begin
                        held_byte_next = clni_pkg::init_byte(4'd0);
                        held_rs_next   = 1'b0;
                        phase_next     = PH_HI_E;
                        timer_next     = clni_pkg::ticks_of(pulse_ticks_reg);
                        pins_next      = {held_byte_next[7:4], 1'b1, 1'b0};
                    end
                    PH_HI_E:
                    begin
                        phase_next   = PH_HI_L;
                        timer_next   = clni_pkg::ticks_of(pulse_ticks_reg);
                        pins_next[1] = 1'b0;
                    end
                    PH_HI_L:
                    begin
                        // the first four init steps are single nibbles
                        if (init_active_next && init_step_next < clni_pkg::INIT_NIBS)
                        begin
                            phase_next = PH_WAIT;
                            timer_next = clni_pkg::ticks_of((init_step_next == 4'd0) ?
                                         first_init_wait_reg : short_wait_reg);
                        end
                        else
                        begin
                            phase_next = PH_LO_E;
                            timer_next = clni_pkg::ticks_of(pulse_ticks_reg);
                            pins_next  = {held_byte_next[3:0], 1'b1, held_rs_next};
                        end
                    end
                    PH_LO_E:
                    begin
                        phase_next   = PH_LO_L;
                        timer_next   = clni_pkg::ticks_of(pulse_ticks_reg);
                        pins_next[1] = 1'b0;
                    end
                    PH_LO_L:
                    begin
                        phase_next = PH_WAIT;
                        // clear and home need the long wait, character bytes never do
                        if (!held_rs_next && (held_byte_next == clni_pkg::INSTR_CLEAR ||
                                              held_byte_next == clni_pkg::INSTR_HOME))
                        begin
                            timer_next = clni_pkg::ticks_of(long_wait_reg);
                        end
                        else
                        begin
                            timer_next = clni_pkg::ticks_of(short_wait_reg);
                        end
                    end
                    PH_WAIT:
                    begin
                        nstep = init_step_next + 4'd1;
                        if (init_active_next && nstep < clni_pkg::INIT_LEN)
                        begin
                            init_step_next = nstep;
                            held_byte_next = clni_pkg::init_byte(nstep);
                            held_rs_next   = 1'b0;
                            phase_next     = PH_HI_E;
                            timer_next     = clni_pkg::ticks_of(pulse_ticks_reg);
                            pins_next      = {held_byte_next[7:4], 1'b1, 1'b0};
                        end
                        else
                        begin
                            init_active_next = 1'b0;
                            init_step_next   = 4'd0;
                            phase_next       = PH_IDLE;
                            timer_next       = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            timer_reg       <= '0;
            held_byte_reg   <= 8'd0;
            held_rs_reg     <= 1'b0;
            init_step_reg   <= 4'd0;
            init_active_reg <= 1'b0;
            pins_reg        <= 6'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            timer_reg       <= timer_next;
            held_byte_reg   <= held_byte_next;
            held_rs_reg     <= held_rs_next;
            init_step_reg   <= init_step_next;
            init_active_reg <= init_active_next;
            pins_reg        <= pins_next;
        end
    end

    a_rej_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.rejected |-> phase_reg != PH_IDLE)
        else $error("request rejected while idle");

    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> timer_reg == '0)
        else $error("timer running while idle");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        init_step_reg < clni_pkg::INIT_LEN)
        else $error("init step out of range");

    a_step_needs_init: assert property (@(posedge clk) disable iff (!rst_n)
        !init_active_reg |-> init_step_reg == 4'd0)
        else $error("init step set outside power-up sequence");

    a_hold_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(timer_reg) && $stable(pins_reg))
        else $error("sequencer moved without a tick");

endmodule

// ===== src/char_lcd_nibble_interface_unit.sv =====
`timescale 1ns / 1ps

// a tick item is held in the input register and its result in the output register
// throughput: one tick item per cycle unless the sink stalls, set by the single-pass
//   sequencer update between the input register and the output register
// reset (rst_n, asynchronous, active low): sequencer idle, pins low, timing
//   registers at 40, 5, 1, 1, 2 ticks, both stages empty
module char_lcd_nibble_interface_unit (
    input  logic        clk,
    input  logic        rst_n,
    // tick items in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], column[13:8], line_two[14], zero[15]
    input  logic [2:0]  s_tuser,   // command[2:0]
    // pin results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // reg_select[0], enable_pin[1], data_nibble[5:2],
                                   // busy_res[6], rejected[7]
    // timing register writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic              item_valid;
    clni_pkg::item_t   item;
    clni_pkg::res_t    res;
    clni_pkg::cfg_wr_t cfg;
    logic              advance;

    logic              out_valid_reg;
    clni_pkg::res_t    out_reg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // a held item runs its tick when the output register can take the result
    assign advance = item_valid && (!out_valid_reg || m_tready);

    clni_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // tick sequencer: phases, timer, power-up steps and pin levels
    clni_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .item  (item),
        .res   (res)
    );

    // output register, keeps the last result while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
